### hdl/wqvt_pkg.sv
// ----------------------------------------------------------------------------
// wqvt_pkg: shared types and constants of the weighted quorum vote tally
// Request and response structs, command and status codes, shared-unit
// opcodes, and the default parameter values of the block.
// ----------------------------------------------------------------------------
package wqvt_pkg;

  // Default parameter values
  localparam int DEF_MEMBERS     = 16;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int DEF_HASH_BITS   = 64;

  // Tally and total width, saturation ceiling
  localparam int            SUM_W   = 20;
  localparam logic [19:0]   SUM_MAX = 20'hFFFFF;

  // Request commands
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_PROMISE = 2'd1;
  localparam logic [1:0] CMD_STOP    = 2'd2;
  localparam logic [1:0] CMD_SETW    = 2'd3;

  // Response status codes
  localparam logic [3:0] ST_STARTED   = 4'd0;
  localparam logic [3:0] ST_BUSY_REF  = 4'd1;
  localparam logic [3:0] ST_RECORDED  = 4'd2;
  localparam logic [3:0] ST_IGNORED   = 4'd3;
  localparam logic [3:0] ST_COMMIT    = 4'd4;
  localparam logic [3:0] ST_MISMATCH  = 4'd5;
  localparam logic [3:0] ST_STOPPED   = 4'd6;
  localparam logic [3:0] ST_WSET      = 4'd7;
  localparam logic [3:0] ST_WREFUSED  = 4'd8;

  // Shared unit opcodes
  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_GT  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  member;
    logic [63:0] hash_value;
    logic [15:0] weight;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] leader_hash;
    logic [19:0] leader_weight;
  } out_rsp_t;

endpackage

### hdl/wqvt_ram.sv
// ----------------------------------------------------------------------------
// wqvt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module wqvt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/wqvt_alu.sv
// ----------------------------------------------------------------------------
// wqvt_alu: shared arithmetic and compare unit
// Add, subtract or greater-than on the tally/total operands, a saturated copy
// of the result, and a hash equality compare.
// ----------------------------------------------------------------------------
module wqvt_alu import wqvt_pkg::*; #(
  parameter int AW = 22,
  parameter int HB = DEF_HASH_BITS
) (
  input  logic [1:0]       op,
  input  logic [AW-1:0]    a,
  input  logic [AW-1:0]    b,
  input  logic [HB-1:0]    ha,
  input  logic [HB-1:0]    hb,
  output logic [AW-1:0]    res,
  output logic [SUM_W-1:0] res_sat,
  output logic             gt,
  output logic             eq
);

  // Adder / subtractor
  always_comb begin
    case (op)
      ALU_SUB: res = a - b;
      default: res = a + b;
    endcase
  end

  // Clamp to the tally width
  assign res_sat = (res > AW'(SUM_MAX)) ? SUM_MAX : res[SUM_W-1:0];

  // Magnitude and hash compares
  assign gt = (op == ALU_GT) && (a > b);
  assign eq = (ha == hb);

endmodule

### hdl/weighted_quorum_vote_tally_unit.sv
// ----------------------------------------------------------------------------
// weighted_quorum_vote_tally_unit: weighted quorum vote tally
// Requests arrive on the in_ channel (valid/ready) as an in_req_t: set a
// member weight, start a round with its expected hash, promise a vote for a
// hash, or stop. Every request yields exactly one out_rsp_t on the out_
// channel (valid/ready) carrying a status and the current leading hash and
// its tally. The block takes one request at a time: in_ready is high only
// while the sequencer is idle.
// Start, stop and refused or ignored requests go straight to the output
// stage; set weight steps through subtract old weight, add new weight and
// the output stage. A promise adds the member weight to the tally, updates
// the leader, checks for a majority and then outputs; when a hash is tallied
// already, a linear search over the tally entries, one compare per cycle
// after a read lead-in, comes first. The next request can be accepted as
// soon as out_valid rises, since in_ready rises together with it.
// Reset (rst_n low, synchronous) clears all member weights, the total and
// the round; the tally RAMs need no clearing since only filled entries are
// read. A stalled receiver (out_ready low) holds the response in the output
// register; the next request is taken meanwhile and its response waits.
// ----------------------------------------------------------------------------
module weighted_quorum_vote_tally_unit import wqvt_pkg::*; #(
  parameter int MEMBERS     = DEF_MEMBERS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  parameter int HASH_BITS   = DEF_HASH_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp
);

  localparam int WB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int MIW   = $clog2(MEMBERS);
  localparam int CW    = $clog2(MEMBERS + 1);
  localparam int TOT_W = WB + MIW;
  localparam int AW    = (TOT_W > SUM_W + 1) ? TOT_W : SUM_W + 1;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WSUB = 4'd1;
  localparam logic [3:0] S_WADD = 4'd2;
  localparam logic [3:0] S_SRCH = 4'd3;
  localparam logic [3:0] S_TRD  = 4'd4;
  localparam logic [3:0] S_ADD  = 4'd5;
  localparam logic [3:0] S_LEAD = 4'd6;
  localparam logic [3:0] S_MAJ  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // Control registers
  logic [3:0]         state_r,    state_nxt;
  logic               busy_r,     busy_nxt;
  logic [HASH_BITS-1:0] exp_r,    exp_nxt;
  logic [MEMBERS-1:0] wvld_r,     wvld_nxt;
  logic [AW-1:0]      tot_r,      tot_nxt;
  logic [SUM_W-1:0]   tot_sat_r,  tot_sat_nxt;
  logic [MEMBERS-1:0] voted_r,    voted_nxt;
  logic [CW-1:0]      cnt_r,      cnt_nxt;
  logic [HASH_BITS-1:0] lead_hash_r, lead_hash_nxt;
  logic [SUM_W-1:0]   lead_w_r,   lead_w_nxt;
  logic               cmp_vld_r,  cmp_vld_nxt;
  logic               out_vld_r,  out_vld_nxt;

  // Payload registers
  logic [MIW-1:0]       mem_idx_r, mem_idx_nxt;
  logic [HASH_BITS-1:0] hash_r,    hash_nxt;
  logic [WB-1:0]        neww_r,    neww_nxt;
  logic [MIW-1:0]       idx_r,     idx_nxt;
  logic [MIW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [MIW-1:0]       slot_r,    slot_nxt;
  logic                 new_r,     new_nxt;
  logic [SUM_W-1:0]     tw_r,      tw_nxt;
  out_rsp_t             res_r,     res_nxt;
  out_rsp_t             out_r,     out_nxt;

  // Memory and shared unit wiring
  logic [MIW-1:0]       in_idx;
  logic                 member_ok;
  logic                 accept;
  logic [MIW-1:0]       wram_raddr;
  logic [WB-1:0]        wram_rdata;
  logic [WB-1:0]        mw;
  logic [HASH_BITS-1:0] hram_rdata;
  logic [SUM_W-1:0]     tram_rdata;
  logic [1:0]           alu_op;
  logic [AW-1:0]        alu_a, alu_b, alu_res;
  logic [SUM_W-1:0]     alu_res_sat;
  logic                 alu_gt, alu_eq;
  logic [HASH_BITS-1:0] alu_ha, alu_hb;

  assign in_idx    = MIW'(in_req.member);
  assign member_ok = 32'(in_req.member) < MEMBERS;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_vld_r;
  assign out_rsp   = out_r;

  // Member weight of the addressed member; unwritten entries read as zero
  assign wram_raddr = (state_r == S_IDLE) ? in_idx : mem_idx_r;
  assign mw         = wvld_r[mem_idx_r] ? wram_rdata : '0;

  wqvt_ram #(.WIDTH(WB), .DEPTH(MEMBERS)) u_wram (
    .clk   (clk),
    .we    (state_r == S_WSUB),
    .waddr (mem_idx_r),
    .wdata (neww_r),
    .raddr (wram_raddr),
    .rdata (wram_rdata)
  );

  // Tally hash per entry
  wqvt_ram #(.WIDTH(HASH_BITS), .DEPTH(MEMBERS)) u_hram (
    .clk   (clk),
    .we    ((state_r == S_ADD) && new_r),
    .waddr (slot_r),
    .wdata (hash_r),
    .raddr (idx_r),
    .rdata (hram_rdata)
  );

  // Tally weight per entry
  wqvt_ram #(.WIDTH(SUM_W), .DEPTH(MEMBERS)) u_tram (
    .clk   (clk),
    .we    (state_r == S_ADD),
    .waddr (slot_r),
    .wdata (alu_res_sat),
    .raddr (slot_r),
    .rdata (tram_rdata)
  );

  // Operand select for the shared unit
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    alu_ha = hram_rdata;
    alu_hb = hash_r;
    case (state_r)
      S_WSUB: begin
        alu_op = ALU_SUB;
        alu_a  = tot_r;
        alu_b  = AW'(mw);
      end
      S_WADD: begin
        alu_a = tot_r;
        alu_b = AW'(neww_r);
      end
      S_ADD: begin
        alu_a = new_r ? '0 : AW'(tram_rdata);
        alu_b = AW'(mw);
      end
      S_LEAD: begin
        alu_op = ALU_GT;
        alu_a  = AW'(tw_r);
        alu_b  = AW'(lead_w_r);
      end
      S_MAJ: begin
        alu_op = ALU_GT;
        alu_a  = AW'({lead_w_r, 1'b0});
        alu_b  = AW'(tot_sat_r);
        alu_ha = lead_hash_r;
        alu_hb = exp_r;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  wqvt_alu #(.AW(AW), .HB(HASH_BITS)) u_alu (
    .op      (alu_op),
    .a       (alu_a),
    .b       (alu_b),
    .ha      (alu_ha),
    .hb      (alu_hb),
    .res     (alu_res),
    .res_sat (alu_res_sat),
    .gt      (alu_gt),
    .eq      (alu_eq)
  );

  // Sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    exp_nxt       = exp_r;
    wvld_nxt      = wvld_r;
    tot_nxt       = tot_r;
    tot_sat_nxt   = tot_sat_r;
    voted_nxt     = voted_r;
    cnt_nxt       = cnt_r;
    lead_hash_nxt = lead_hash_r;
    lead_w_nxt    = lead_w_r;
    cmp_vld_nxt   = cmp_vld_r;
    out_vld_nxt   = out_vld_r && !out_ready;
    mem_idx_nxt   = mem_idx_r;
    hash_nxt      = hash_r;
    neww_nxt      = neww_r;
    idx_nxt       = idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    slot_nxt      = slot_r;
    new_nxt       = new_r;
    tw_nxt        = tw_r;
    res_nxt       = res_r;
    out_nxt       = out_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Response carries the leader as it stands before this request; a promise replaces it after its tally
          res_nxt.leader_hash   = 64'(lead_hash_r);
          res_nxt.leader_weight = lead_w_r;
          mem_idx_nxt           = in_idx;
          hash_nxt              = in_req.hash_value[HASH_BITS-1:0];
          neww_nxt              = in_req.weight[WB-1:0];
          state_nxt             = S_OUT;
          case (in_req.cmd)
            CMD_START: begin
              if (busy_r) begin
                res_nxt.status = ST_BUSY_REF;
              end else begin
                busy_nxt       = 1'b1;
                exp_nxt        = in_req.hash_value[HASH_BITS-1:0];
                res_nxt.status = ST_STARTED;
              end
            end
            CMD_STOP: begin
              res_nxt.status = ST_STOPPED;
              busy_nxt       = 1'b0;
              exp_nxt        = '0;
              voted_nxt      = '0;
              cnt_nxt        = '0;
              lead_hash_nxt  = '0;
              lead_w_nxt     = '0;
            end
            CMD_SETW: begin
              if (busy_r || !member_ok) begin
                res_nxt.status = ST_WREFUSED;
              end else begin
                state_nxt = S_WSUB;
              end
            end
            default: begin
              if (busy_r && member_ok && !voted_r[in_idx]) begin
                voted_nxt[in_idx] = 1'b1;
                if (cnt_r == '0) begin
                  slot_nxt  = '0;
                  new_nxt   = 1'b1;
                  state_nxt = S_ADD;
                end else begin
                  idx_nxt     = '0;
                  cmp_vld_nxt = 1'b0;
                  state_nxt   = S_SRCH;
                end
              end else begin
                res_nxt.status = ST_IGNORED;
              end
            end
          endcase
        end
      end

      // Total minus the member's old weight, then store the new weight
      S_WSUB: begin
        tot_nxt            = alu_res;
        wvld_nxt[mem_idx_r] = 1'b1;
        state_nxt          = S_WADD;
      end

      // Total plus the new weight
      S_WADD: begin
        tot_nxt        = alu_res;
        tot_sat_nxt    = alu_res_sat;
        res_nxt.status = ST_WSET;
        state_nxt      = S_OUT;
      end

      // Linear search of the tally entries, one compare per cycle
      S_SRCH: begin
        idx_nxt     = idx_r + MIW'(1);
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = idx_r;
        if (cmp_vld_r) begin
          if (alu_eq) begin
            slot_nxt  = cmp_idx_r;
            new_nxt   = 1'b0;
            state_nxt = S_TRD;
          end else if (CW'(cmp_idx_r) + CW'(1) == cnt_r) begin
            slot_nxt  = MIW'(cnt_r);
            new_nxt   = 1'b1;
            state_nxt = S_ADD;
          end
        end
      end

      // Wait for the tally weight read
      S_TRD: begin
        state_nxt = S_ADD;
      end

      // Add the member weight to the tally and write it back
      S_ADD: begin
        tw_nxt = alu_res_sat;
        if (new_r) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = S_LEAD;
      end

      // Take the lead only on a strictly greater tally
      S_LEAD: begin
        if (alu_gt) begin
          lead_hash_nxt = hash_r;
          lead_w_nxt    = tw_r;
        end
        state_nxt = S_MAJ;
      end

      // Majority check: twice the leader's tally against the total
      S_MAJ: begin
        res_nxt.leader_hash   = 64'(lead_hash_r);
        res_nxt.leader_weight = lead_w_r;
        if (alu_gt) begin
          res_nxt.status = alu_eq ? ST_COMMIT : ST_MISMATCH;
          busy_nxt       = 1'b0;
          exp_nxt        = '0;
          voted_nxt      = '0;
          cnt_nxt        = '0;
          lead_hash_nxt  = '0;
          lead_w_nxt     = '0;
        end else begin
          res_nxt.status = ST_RECORDED;
        end
        state_nxt = S_OUT;
      end

      // Hand the response to the output register once it is free
      S_OUT: begin
        if (!out_vld_r || out_ready) begin
          out_vld_nxt = 1'b1;
          out_nxt     = res_r;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      exp_r       <= '0;
      wvld_r      <= '0;
      tot_r       <= '0;
      tot_sat_r   <= '0;
      voted_r     <= '0;
      cnt_r       <= '0;
      lead_hash_r <= '0;
      lead_w_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      exp_r       <= exp_nxt;
      wvld_r      <= wvld_nxt;
      tot_r       <= tot_nxt;
      tot_sat_r   <= tot_sat_nxt;
      voted_r     <= voted_nxt;
      cnt_r       <= cnt_nxt;
      lead_hash_r <= lead_hash_nxt;
      lead_w_r    <= lead_w_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    mem_idx_r <= mem_idx_nxt;
    hash_r    <= hash_nxt;
    neww_r    <= neww_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
    new_r     <= new_nxt;
    tw_r      <= tw_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

endmodule
